### design/sobel_edge_rgb_unit_macros.svh
// Assertion macros shared by the Sobel edge RTL.
`ifndef SOBEL_EDGE_RGB_UNIT_MACROS_SVH
`define SOBEL_EDGE_RGB_UNIT_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define SED_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sobel edge check failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define SED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sobel edge check failed");

`endif

### design/sed_pkg.sv
// Types, constants and the square-root step shared by the Sobel edge unit.
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int NUM_LANES = 3;
    localparam int WIN_N     = 9;
    localparam int GRAD_W    = 10;
    localparam int SUM_W     = 2 * GRAD_W + 1;
    localparam int ROOT_IN_W = 16;
    localparam int REM_W     = 10;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Above this sum of squares the rounded root is at least 255.
    localparam int               SAT_LIMIT = 65280;
    localparam logic [CH_W-1:0]  MAG_MAX   = 8'd255;

    typedef struct packed {
        logic            cmd;
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
    } pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic            frame_last;
    } result_t;

    typedef struct packed {
        logic load_grad;
        logic load_sum;
        logic load_root_hi;
        logic load_root_lo;
    } sed_lane_ctl_t;

    typedef struct packed {
        logic [CH_W-1:0]  root;
        logic [REM_W-1:0] rem;
    } root_state_t;

    // One restoring square-root step: brings in two more radicand bits and
    // decides one more root bit. The remainder never exceeds twice the root.
    function automatic root_state_t root_step(input root_state_t st, input logic [1:0] pair);
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        root_state_t      nx;
        shifted = {st.rem[REM_W-3:0], pair};
        trial   = {1'b0, st.root[CH_W-2:0], 2'b01};
        if (shifted >= trial)
        begin
            nx.rem  = shifted - trial;
            nx.root = {st.root[CH_W-2:0], 1'b1};
        end
        else
        begin
            nx.rem  = shifted;
            nx.root = {st.root[CH_W-2:0], 1'b0};
        end
        return nx;
    endfunction

endpackage

`default_nettype wire

### design/sobel_edge_rgb_unit.sv
// Top level of the streaming 3x3 Sobel edge magnitude unit for RGB pixels.
//
//   channel   | direction | handshake                    | beat
//   ----------+-----------+------------------------------+---------------------------
//   pixel     | in        | pixel_valid / pixel_stall    | cmd, in_red/green/blue
//   result    | out       | result_valid / result_stall  | out_red/green/blue, last
//   cfg       | in        | cfg_we, cfg_index, cfg_data  | image_width, image_height
//
// One pixel beat is taken per clock unless stalled; a window's last beat passes the
// window, lane and output registers, and a frame lags by one row plus one pixel.
// Line stores are read and written in the accept cycle, so no cycle is spent on
// a read-modify-write; the four-step root halves set the pipeline depth.
// Reset clears counters, window and valid bits; line stores need no clearing.
// A stalled result holds; pixel beats keep coming while earlier stages have room.
`timescale 1ns / 1ps
`default_nettype none
`include "sobel_edge_rgb_unit_macros.svh"

module sobel_edge_rgb_unit
    import sed_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    output logic                 pixel_stall,
    input  pixel_t               pixel,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WVW  = $clog2(MAX_WIDTH + 1);
    localparam int HVW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 2);
    localparam int EW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int NSTG = 7;

    // Stage 0 holds the accepted beat, stage 1 the 3x3 window, stages 2 to 5
    // sit in the lanes and stage 6 is the merged output register.
    logic [NSTG-1:0]      v_reg;
    logic [NSTG-1:0]      hold;
    logic [5:1]           last_reg;

    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     height_reg;
    logic [WVW-1:0]       wid_eff;
    logic [HVW-1:0]       hgt_eff;
    logic [WVW+HVW-1:0]   area;
    logic [EW-1:0]        total_reg;

    logic [CW-1:0]        col_reg;
    logic [RW-1:0]        row_reg;
    logic [EW-1:0]        cnt_reg;
    logic [WVW-1:0]       col_inc;
    logic                 col_wrap;
    logic                 in_frame;
    logic                 drop;
    logic                 acc_item;
    logic                 emit_now;
    logic                 last_now;
    logic [PIX_W-1:0]     pix_in;

    logic [PIX_W-1:0]     rd0;
    logic [PIX_W-1:0]     rd1;

    logic [PIX_W-1:0]     a_pix_reg;
    logic                 a_col0_reg;
    logic                 a_up_ok_reg;
    logic                 a_mid_ok_reg;
    logic                 a_par_reg;
    logic                 a_emit_reg;
    logic                 a_last_reg;

    logic [PIX_W-1:0]     up_pix;
    logic [PIX_W-1:0]     mid_pix;
    logic [5:0][PIX_W-1:0] win_reg;
    logic [5:0][PIX_W-1:0] win_next;
    logic [WIN_N-1:0][PIX_W-1:0] calc_reg;
    logic [WIN_N-1:0][PIX_W-1:0] calc_next;

    sed_lane_ctl_t        lane_ctl;
    logic [NUM_LANES-1:0][CH_W-1:0] lane_mag;
    result_t              result_reg;

    // Effective frame size saturates into 1..MAX.
    always_comb
    begin
        if (width_reg == '0)
        begin
            wid_eff = WVW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            wid_eff = WVW'(MAX_WIDTH);
        end
        else
        begin
            wid_eff = WVW'(width_reg);
        end
        if (height_reg == '0)
        begin
            hgt_eff = HVW'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            hgt_eff = HVW'(MAX_HEIGHT);
        end
        else
        begin
            hgt_eff = HVW'(height_reg);
        end
    end

    assign area = {{HVW{1'b0}}, wid_eff} * {{WVW{1'b0}}, hgt_eff};

    // The first result of a frame comes a row after its first beat, so registering
    // the result count after a register write is harmless.
    always_ff @(posedge clk)
    begin
        total_reg <= EW'(area - 1'b1);
    end

    // Backpressure runs back through occupied stages only.
    always_comb
    begin
        hold[NSTG-1] = v_reg[NSTG-1] && result_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            hold[k] = v_reg[k] && hold[k+1];
        end
    end

    assign pixel_stall = hold[0];

    always_comb
    begin
        in_frame = (row_reg < hgt_eff);
        drop     = pixel.cmd && in_frame;
        acc_item = pixel_valid && !hold[0] && !drop;
        emit_now = (row_reg >= RW'(2)) || ((row_reg == RW'(1)) && (col_reg != '0));
        last_now = emit_now && (cnt_reg >= total_reg);
        col_inc  = WVW'(col_reg) + WVW'(1);
        col_wrap = (col_inc >= wid_eff);
        pix_in   = in_frame ? {pixel.in_red, pixel.in_green, pixel.in_blue} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(RESET_WIDTH);
            height_reg <= CFG_W'(RESET_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
            cnt_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
            endcase
            col_reg <= '0;
            row_reg <= '0;
            cnt_reg <= '0;
        end
        else if (acc_item)
        begin
            if (last_now)
            begin
                col_reg <= '0;
                row_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                col_reg <= col_wrap ? '0 : col_inc[CW-1:0];
                if (col_wrap)
                begin
                    row_reg <= row_reg + RW'(1);
                end
                if (emit_now)
                begin
                    cnt_reg <= cnt_reg + EW'(1);
                end
            end
        end
    end

    // Two banks alternate by row parity: the bank of the current row still
    // holds the row two above, the other bank holds the row just above.
    sed_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_bank0 (
        .clk   (clk),
        .we    (acc_item && !row_reg[0]),
        .rd_en (acc_item),
        .addr  (col_reg),
        .wdata (pix_in),
        .rdata (rd0)
    );

    sed_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_bank1 (
        .clk   (clk),
        .we    (acc_item && row_reg[0]),
        .rd_en (acc_item),
        .addr  (col_reg),
        .wdata (pix_in),
        .rdata (rd1)
    );

    always_ff @(posedge clk)
    begin
        if (!hold[0])
        begin
            a_pix_reg    <= pix_in;
            a_col0_reg   <= (col_reg == '0);
            a_up_ok_reg  <= (row_reg >= RW'(2));
            a_mid_ok_reg <= (row_reg >= RW'(1));
            a_par_reg    <= row_reg[0];
            a_emit_reg   <= emit_now;
            a_last_reg   <= last_now;
        end
    end

    // At the first column the window closes out the previous row, whose
    // right neighbor lies outside the frame.
    always_comb
    begin
        up_pix  = a_up_ok_reg ? (a_par_reg ? rd1 : rd0) : '0;
        mid_pix = a_mid_ok_reg ? (a_par_reg ? rd0 : rd1) : '0;
        for (int i = 0; i < 6; i++)
        begin
            calc_next[i] = win_reg[i];
        end
        calc_next[6] = a_col0_reg ? '0 : up_pix;
        calc_next[7] = a_col0_reg ? '0 : mid_pix;
        calc_next[8] = a_col0_reg ? '0 : a_pix_reg;
        for (int i = 0; i < 3; i++)
        begin
            win_next[i] = a_col0_reg ? '0 : win_reg[i+3];
        end
        win_next[3] = up_pix;
        win_next[4] = mid_pix;
        win_next[5] = a_pix_reg;
        if (a_last_reg)
        begin
            win_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (cfg_we)
        begin
            win_reg <= '0;
        end
        else if (v_reg[0] && !hold[1])
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (!hold[0])
            begin
                v_reg[0] <= acc_item;
            end
            if (!hold[1])
            begin
                v_reg[1] <= v_reg[0] && a_emit_reg;
            end
            for (int k = 2; k < NSTG; k++)
            begin
                if (!hold[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold[1])
        begin
            calc_reg    <= calc_next;
            last_reg[1] <= a_last_reg;
        end
        for (int k = 2; k <= 5; k++)
        begin
            if (!hold[k])
            begin
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    assign lane_ctl.load_grad    = !hold[2];
    assign lane_ctl.load_sum     = !hold[3];
    assign lane_ctl.load_root_hi = !hold[4];
    assign lane_ctl.load_root_lo = !hold[5];

    for (genvar ch = 0; ch < NUM_LANES; ch++)
    begin : g_lane
        logic [WIN_N-1:0][CH_W-1:0] win_bytes;

        always_comb
        begin
            for (int i = 0; i < WIN_N; i++)
            begin
                win_bytes[i] = calc_reg[i][PIX_W-1-CH_W*ch -: CH_W];
            end
        end

        sed_lane u_lane (
            .clk (clk),
            .ctl (lane_ctl),
            .win (win_bytes),
            .mag (lane_mag[ch])
        );
    end

    // The three lanes finish together and merge into one result beat.
    always_ff @(posedge clk)
    begin
        if (!hold[NSTG-1])
        begin
            result_reg.out_red    <= lane_mag[0];
            result_reg.out_green  <= lane_mag[1];
            result_reg.out_blue   <= lane_mag[2];
            result_reg.frame_last <= last_reg[5];
        end
    end

    assign result_valid = v_reg[NSTG-1];
    assign result       = result_reg;

    `SED_ASSERT_ALWAYS(a_col_in_row, ({1'b0, col_reg} < {1'b0, wid_eff}))
    `SED_ASSERT_ALWAYS(a_row_bound, (row_reg <= hgt_eff + 1'b1))
    `SED_ASSERT_NEXT(a_last_restarts, (acc_item && last_now), (row_reg == '0 && col_reg == '0 && cnt_reg == '0))
    `SED_ASSERT_NEXT(a_flush_dropped, (pixel_valid && !pixel_stall && drop), (!v_reg[0]))

endmodule

`default_nettype wire

### design/sed_line_buf.sv
// Single-port line store with registered read-before-write data.
`timescale 1ns / 1ps
`default_nettype none

module sed_line_buf
    import sed_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [PIX_W-1:0]         wdata,
    output logic [PIX_W-1:0]         rdata
);

    logic [PIX_W-1:0] mem [DEPTH];

    // A read and a write to the same entry in one cycle return the old entry.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

endmodule

`default_nettype wire

### design/sed_lane.sv
// One color lane: Sobel gradients, sum of squares and rounded square root.
`timescale 1ns / 1ps
`default_nettype none

module sed_lane
    import sed_pkg::*;
(
    input  logic                         clk,
    input  sed_lane_ctl_t                ctl,
    input  logic [WIN_N-1:0][CH_W-1:0]   win,
    output logic [CH_W-1:0]              mag
);

    logic [GRAD_W-1:0]   pos_x;
    logic [GRAD_W-1:0]   neg_x;
    logic [GRAD_W-1:0]   pos_y;
    logic [GRAD_W-1:0]   neg_y;
    logic [GRAD_W-1:0]   ax_next;
    logic [GRAD_W-1:0]   ay_next;
    logic [GRAD_W-1:0]   ax_reg;
    logic [GRAD_W-1:0]   ay_reg;
    logic [2*GRAD_W-1:0] sq_x;
    logic [2*GRAD_W-1:0] sq_y;
    logic [SUM_W-1:0]    sum_next;
    logic [ROOT_IN_W-1:0] sum_reg;
    logic                sat_sum_reg;
    root_state_t         hi_next;
    root_state_t         hi_reg;
    logic [CH_W-1:0]     lo_bits_reg;
    logic                sat_hi_reg;
    root_state_t         lo_state;
    logic                round_up;
    logic [CH_W-1:0]     mag_next;
    logic [CH_W-1:0]     mag_reg;

    // Window index is column * 3 + row; the left and top taps are negative.
    always_comb
    begin
        pos_x = {2'b00, win[6]} + {1'b0, win[7], 1'b0} + {2'b00, win[8]};
        neg_x = {2'b00, win[0]} + {1'b0, win[1], 1'b0} + {2'b00, win[2]};
        pos_y = {2'b00, win[2]} + {1'b0, win[5], 1'b0} + {2'b00, win[8]};
        neg_y = {2'b00, win[0]} + {1'b0, win[3], 1'b0} + {2'b00, win[6]};
        ax_next = (pos_x >= neg_x) ? (pos_x - neg_x) : (neg_x - pos_x);
        ay_next = (pos_y >= neg_y) ? (pos_y - neg_y) : (neg_y - pos_y);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_grad)
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
        end
    end

    assign sq_x     = {{GRAD_W{1'b0}}, ax_reg} * {{GRAD_W{1'b0}}, ax_reg};
    assign sq_y     = {{GRAD_W{1'b0}}, ay_reg} * {{GRAD_W{1'b0}}, ay_reg};
    assign sum_next = {1'b0, sq_x} + {1'b0, sq_y};

    always_ff @(posedge clk)
    begin
        if (ctl.load_sum)
        begin
            sum_reg     <= sum_next[ROOT_IN_W-1:0];
            sat_sum_reg <= (sum_next > SAT_LIMIT);
        end
    end

    // Upper four root bits come from the upper byte of the radicand.
    always_comb
    begin
        hi_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            hi_next = root_step(hi_next, sum_reg[ROOT_IN_W-1-2*i -: 2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_root_hi)
        begin
            hi_reg      <= hi_next;
            lo_bits_reg <= sum_reg[CH_W-1:0];
            sat_hi_reg  <= sat_sum_reg;
        end
    end

    // The root rounds up when the remainder is above the root itself.
    always_comb
    begin
        lo_state = hi_reg;
        for (int i = 0; i < 4; i++)
        begin
            lo_state = root_step(lo_state, lo_bits_reg[CH_W-1-2*i -: 2]);
        end
        round_up = (lo_state.rem > {2'b00, lo_state.root});
        if (sat_hi_reg || (lo_state.root == MAG_MAX))
        begin
            mag_next = MAG_MAX;
        end
        else
        begin
            mag_next = lo_state.root + {{(CH_W-1){1'b0}}, round_up};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_root_lo)
        begin
            mag_reg <= mag_next;
        end
    end

    assign mag = mag_reg;

endmodule

`default_nettype wire
